>>> rtl/pwmcl_pkg.sv
// Shared constants and widths for the soft-started PWM current loop.
package pwmcl_pkg;

    // Fixed system constants.
    localparam int PWM_PERIOD       = 1024;
    localparam int HALF_PERIOD      = PWM_PERIOD / 2;
    localparam int STEPS_PER_PERIOD = 256;
    localparam int STEP_W           = $clog2(STEPS_PER_PERIOD);
    localparam int ADC_RANGE        = 4096;
    localparam int ADC_MID          = ADC_RANGE / 2;

    // Field and datapath widths.
    localparam int SMP_W   = 12;
    localparam int CMP_W   = 10;
    localparam int SCALE_W = 24;
    localparam int FILT_W  = 20;
    localparam int DELTA_W = 22;
    localparam int MAG_W   = 21;
    localparam int E5_W    = 25;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_W  = 24;
    localparam int DRV_W   = PROD_W - FRAC_W;

    // Reciprocal of five for exact truncating division of values below 2^21.
    localparam int DIV5_SHIFT = 24;
    localparam logic [MUL_W-1:0] RECIP5 = MUL_W'(((1 << DIV5_SHIFT) + 4) / 5);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    // Period counter codes.
    localparam logic [1:0] PERIOD_FIRST  = 2'd0;
    localparam logic [1:0] PERIOD_SECOND = 2'd1;
    localparam logic [1:0] PERIOD_LATER  = 2'd2;

endpackage

>>> rtl/pwmcl_mul.sv
// Shared signed multiplier with a registered product.
module pwmcl_mul
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [pwmcl_pkg::MUL_W-1:0]   a,
    input  logic signed [pwmcl_pkg::MUL_W-1:0]   b,
    output logic signed [pwmcl_pkg::PROD_W-1:0]  p
);
    import pwmcl_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/pwm_current_loop_with_soft_start_core.sv
// Top level of the soft-started PWM current loop.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  one ADC sample pair per item
//  m_axis    out        m_axis_tvalid/m_axis_tready  PWM compare value and relay flag
//  cfg       in         cfg_valid/cfg_ready          drive_scale register write
//
// The steps are idle, sum, scale and out in the first period; the second period
// adds divide, filter and gain before sum, later periods divide and filter. The
// single shared multiplier serves the divide by five in the current filter after
// the first period, the soft-start gain in the second period only and the drive
// scale, each with a registered product. Reset clears the tick and period
// counters, the current filter and the output valid, and loads drive_scale with
// its default of 1.0 in Q8.16. A stalled output holds the finished item in the
// output register; the sequencer waits in its last step until that register is
// free, and no new item is taken until the previous one has moved there.
module pwm_current_loop_with_soft_start_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] voltage_sample, [23:12] current_sample

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] pwm_compare, [15:10] zero
    output logic        m_axis_tuser,   // [0] relay_on

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data        // [23:0] drive_scale
);
    import pwmcl_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIV,
        S_FNEW,
        S_GAIN,
        S_SUM,
        S_SCALE,
        S_OUT
    } state_t;

    state_t                    state_reg,   state_next;
    logic [SCALE_W-1:0]        scale_reg,   scale_next;
    logic [STEP_W-1:0]         step_reg,    step_next;
    logic [1:0]                period_reg,  period_next;
    logic signed [FILT_W-1:0]  filt_reg,    filt_next;
    logic signed [SMP_W-1:0]   v_reg,       v_next;
    logic signed [SMP_W-1:0]   c_reg,       c_next;
    logic                      neg_reg,     neg_next;
    logic signed [E5_W-1:0]    e5_reg,      e5_next;
    logic signed [E5_W-1:0]    sum_reg,     sum_next;
    logic                      ovalid_reg,  ovalid_next;
    logic [CMP_W-1:0]          cmp_reg,     cmp_next;
    logic                      relay_reg,   relay_next;

    // Shared multiplier.
    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;

    // Datapath intermediates.
    logic [SMP_W:0]            v_wide;
    logic [SMP_W:0]            c_wide;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] delta_neg;
    logic [MAG_W-1:0]          mag;
    logic signed [DELTA_W-1:0] quot;
    logic signed [DELTA_W-1:0] filt_sum;
    logic signed [FILT_W-1:0]  filt_sat;
    logic signed [DELTA_W-1:0] v256_22;
    logic signed [DELTA_W-1:0] e8;
    logic signed [E5_W-1:0]    e5;
    logic signed [PROD_W-1:0]  gain_round;
    logic signed [E5_W-1:0]    t8;
    logic signed [E5_W-1:0]    v256_25;
    logic signed [DRV_W-1:0]   drive;
    logic signed [DRV_W-1:0]   drive_clamp;
    logic [DRV_W-1:0]          drive_off;
    logic                      out_free;

    pwmcl_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(16 - CMP_W){1'b0}}, cmp_reg};
    assign m_axis_tuser  = relay_reg;

    // Center the raw samples at mid-range.
    assign v_wide = {1'b0, s_axis_tdata[SMP_W-1:0]} - (SMP_W + 1)'(ADC_MID);
    assign c_wide = {1'b0, s_axis_tdata[2*SMP_W-1:SMP_W]} - (SMP_W + 1)'(ADC_MID);

    // Filter step: move one fifth of the way from the filter toward the current.
    assign delta     = $signed({{(DELTA_W - SMP_W - 8){c_reg[SMP_W-1]}}, c_reg, 8'b0})
                     - DELTA_W'(filt_reg);
    assign delta_neg = -delta;
    assign mag       = delta[DELTA_W-1] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];

    assign quot      = neg_reg ? -$signed({1'b0, prod[DIV5_SHIFT +: MAG_W]})
                               :  $signed({1'b0, prod[DIV5_SHIFT +: MAG_W]});
    assign filt_sum  = DELTA_W'(filt_reg) + quot;

    always_comb
    begin
        if (filt_sum > DELTA_W'(signed'({1'b0, {(FILT_W-1){1'b1}}})))
        begin
            filt_sat = {1'b0, {(FILT_W-1){1'b1}}};
        end
        else if (filt_sum < DELTA_W'(signed'({1'b1, {(FILT_W-1){1'b0}}})))
        begin
            filt_sat = {1'b1, {(FILT_W-1){1'b0}}};
        end
        else
        begin
            filt_sat = filt_sum[FILT_W-1:0];
        end
    end

    // Error in Q.8 and five times the error.
    assign v256_22 = $signed({{(DELTA_W - SMP_W - 8){v_reg[SMP_W-1]}}, v_reg, 8'b0});
    assign e8      = -v256_22 - DELTA_W'(filt_sat);
    assign e5      = (E5_W'(e8) <<< 2) + E5_W'(e8);

    // Gain term: the soft-start product is divided by the steps per period, rounded
    // toward zero; the steps per period are a power of two.
    assign gain_round = prod + (prod[PROD_W-1] ? PROD_W'(STEPS_PER_PERIOD - 1)
                                               : PROD_W'(0));
    assign v256_25    = E5_W'(v256_22);

    always_comb
    begin
        case (period_reg)
            PERIOD_FIRST:  t8 = '0;
            PERIOD_SECOND: t8 = E5_W'(gain_round >>> STEP_W);
            default:       t8 = e5_reg;
        endcase
    end

    // Drive: floor of the scaled product, saturated to a signed half period.
    assign drive = prod[PROD_W-1:FRAC_W];

    always_comb
    begin
        if (drive >= DRV_W'(HALF_PERIOD))
        begin
            drive_clamp = DRV_W'(HALF_PERIOD - 1);
        end
        else if (drive < -DRV_W'(HALF_PERIOD))
        begin
            drive_clamp = -DRV_W'(HALF_PERIOD);
        end
        else
        begin
            drive_clamp = drive;
        end
    end

    assign drive_off = drive_clamp + DRV_W'(HALF_PERIOD);
    assign out_free  = !ovalid_reg || m_axis_tready;

    // Operand selection for the shared multiplier.
    assign mul_en = (state_reg inside {S_DIV, S_GAIN, S_SCALE});

    always_comb
    begin
        case (state_reg)
            S_DIV:
            begin
                mul_a = $signed({{(MUL_W - MAG_W){1'b0}}, mag});
                mul_b = RECIP5;
            end
            S_GAIN:
            begin
                mul_a = e5_reg;
                mul_b = $signed({{(MUL_W - STEP_W){1'b0}}, step_reg});
            end
            default:
            begin
                mul_a = $signed({{(MUL_W - SCALE_W){1'b0}}, scale_reg});
                mul_b = sum_reg;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        scale_next  = scale_reg;
        step_next   = step_reg;
        period_next = period_reg;
        filt_next   = filt_reg;
        v_next      = v_reg;
        c_next      = c_reg;
        neg_next    = neg_reg;
        e5_next     = e5_reg;
        sum_next    = sum_reg;
        ovalid_next = ovalid_reg;
        cmp_next    = cmp_reg;
        relay_next  = relay_reg;

        if (cfg_valid && cfg_ready)
        begin
            scale_next = cfg_data;
        end

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    v_next = v_wide[SMP_W-1:0];
                    c_next = c_wide[SMP_W-1:0];
                    if (period_reg == PERIOD_FIRST)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                neg_next   = delta[DELTA_W-1];
                state_next = S_FNEW;
            end
            S_FNEW:
            begin
                filt_next = filt_sat;
                e5_next   = e5;
                if (period_reg == PERIOD_SECOND)
                begin
                    state_next = S_GAIN;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_GAIN:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = v256_25 + t8;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    cmp_next    = drive_off[CMP_W-1:0];
                    relay_next  = (period_reg != PERIOD_FIRST);
                    if (step_reg == STEP_W'(STEPS_PER_PERIOD - 1))
                    begin
                        step_next = '0;
                        if (period_reg != PERIOD_LATER)
                        begin
                            period_next = period_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            scale_reg  <= SCALE_RESET;
            step_reg   <= '0;
            period_reg <= PERIOD_FIRST;
            filt_reg   <= '0;
            v_reg      <= '0;
            c_reg      <= '0;
            neg_reg    <= 1'b0;
            e5_reg     <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
            cmp_reg    <= '0;
            relay_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scale_reg  <= scale_next;
            step_reg   <= step_next;
            period_reg <= period_next;
            filt_reg   <= filt_next;
            v_reg      <= v_next;
            c_reg      <= c_next;
            neg_reg    <= neg_next;
            e5_reg     <= e5_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
            cmp_reg    <= cmp_next;
            relay_reg  <= relay_next;
        end
    end

    // The period counter saturates and never reaches the unused code.
    a_period_sat: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != 2'd3)
        else $error("period counter left its range");

    // An accepted item blocks the input until its work is done.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // The tick counter only advances when a result is produced.
    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_OUT |=> $stable(step_reg))
        else $error("tick counter moved outside the output step");

    // The current filter is only updated in its own step.
    a_filt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_FNEW |=> $stable(filt_reg))
        else $error("current filter moved outside the filter step");

    // The relay flag is never raised during the first period.
    a_relay: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> period_reg != PERIOD_FIRST)
        else $error("relay raised in the first period");

endmodule

>>> sim/tb_pwm_current_loop_with_soft_start_core.sv
// Self-checking testbench for the soft-started PWM current loop core.
module tb_pwm_current_loop_with_soft_start_core;

    import pwmcl_pkg::*;

    // Sample pair as it travels on s_axis_tdata: voltage in the low 12 bits.
    typedef struct packed {
        logic [SMP_W-1:0] current;
        logic [SMP_W-1:0] voltage;
    } sample_pair_t;

    // One predicted result item.
    typedef struct packed {
        logic [CMP_W-1:0] compare;
        logic             relay;
    } drive_out_t;

    localparam logic [SMP_W-1:0]   CODE_MAX   = '1;
    localparam logic [SCALE_W-1:0] SCALE_FULL = '1;
    localparam longint FILT_HI = (longint'(1) <<< (FILT_W - 1)) - 1;
    localparam longint FILT_LO = -(longint'(1) <<< (FILT_W - 1));
    localparam int PRESSURE_AT    = 300;
    localparam int PRESSURE_HOLD  = 400;
    localparam int PRINT_LIMIT    = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [11:0] voltage_sample, [23:12] current_sample

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [9:0] pwm_compare, [15:10] zero
    logic        m_axis_tuser;          // [0] relay_on

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;         // [23:0] drive_scale

    pwm_current_loop_with_soft_start_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Loop state as the block should hold it after reset.
    logic [SCALE_W-1:0]       scale_q  = SCALE_RESET;
    int                       tick_cnt = 0;
    logic [1:0]               period_q = PERIOD_FIRST;
    logic signed [FILT_W-1:0] filt_q   = '0;

    sample_pair_t sample_q[$];
    drive_out_t   compare_due[$];

    int  samples_queued = 0;
    int  samples_taken  = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    bit  in_taken       = 1'b0;
    bit  idling_on      = 1'b1;
    bit  pressure_done  = 1'b0;
    int  send_gap       = 0;
    int  stall_left     = 0;

    // Runs one control tick on the local copy of the loop state and returns
    // the compare value and relay flag that the block must produce for it.
    function automatic drive_out_t control_tick(sample_pair_t pair);
        longint     v;
        longint     c;
        longint     delta;
        longint     nf;
        longint     e8;
        longint     t8;
        longint     d;
        drive_out_t r;
        v  = longint'(pair.voltage) - ADC_MID;
        c  = longint'(pair.current) - ADC_MID;
        t8 = 0;
        // The current filter and the feedback term only run once the first
        // period is over; until then the drive is pure feed-forward.
        if (period_q != PERIOD_FIRST)
        begin
            delta = c * 256 - longint'(filt_q);
            nf    = longint'(filt_q) + delta / 5;
            if (nf > FILT_HI)
                nf = FILT_HI;
            if (nf < FILT_LO)
                nf = FILT_LO;
            filt_q = nf[FILT_W-1:0];
            e8 = -(v * 256) - nf;
            // Soft start: the gain ramps with the tick index in the second period.
            if (period_q == PERIOD_SECOND)
                t8 = (longint'(tick_cnt) * 5 * e8) / STEPS_PER_PERIOD;
            else
                t8 = 5 * e8;
        end
        // Arithmetic shift of a signed product floors, as the drive requires.
        d = (longint'(scale_q) * (v * 256 + t8)) >>> 24;
        if (d >= HALF_PERIOD)
            d = HALF_PERIOD - 1;
        else if (d < -HALF_PERIOD)
            d = -HALF_PERIOD;
        d = d + HALF_PERIOD;
        r.compare = d[CMP_W-1:0];
        r.relay   = (period_q != PERIOD_FIRST);
        // The period counter stops at its last code, so the gain stays at one.
        if (tick_cnt == STEPS_PER_PERIOD - 1)
        begin
            tick_cnt = 0;
            if (period_q == PERIOD_FIRST)
                period_q = PERIOD_SECOND;
            else if (period_q == PERIOD_SECOND)
                period_q = PERIOD_LATER;
        end
        else
            tick_cnt = tick_cnt + 1;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int pick;
        if (!idling_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ADC codes cluster around mid-range so that the loop works unsaturated,
    // with full-range noise and the code extremes mixed in.
    function automatic logic [SMP_W-1:0] draw_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return SMP_W'(ADC_MID - 150 + $urandom_range(0, 300));
        if (pick < 88)
            return SMP_W'($urandom_range(0, ADC_RANGE - 1));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CODE_MAX;
            2:       return SMP_W'(ADC_MID - 1);
            default: return SMP_W'(ADC_MID);
        endcase
    endfunction

    task automatic queue_sample(logic [SMP_W-1:0] voltage, logic [SMP_W-1:0] current);
        sample_pair_t pair;
        pair.voltage = voltage;
        pair.current = current;
        sample_q.push_back(pair);
        samples_queued++;
    endtask

    // Waits until every queued item has gone in and every result has come
    // out, then lets the pipeline settle.
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (samples_taken != samples_queued || compare_due.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sender: holds an item until it is taken, then moves on after a gap.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end
            else if (sample_q.size() > 0)
            begin
                s_axis_tdata  <= sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = draw_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block
    // fill up and push back on its input while the sender keeps offering.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!pressure_done && results_seen >= PRESSURE_AT)
        begin
            pressure_done = 1'b1;
            stall_left = PRESSURE_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = draw_gap();
        end
    end

    // Monitor: checks each result against the oldest prediction, tracks
    // register writes, and predicts a result for every item taken.
    always @(posedge clk)
    begin : monitor
        drive_out_t due;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (compare_due.size() == 0)
                    report_mismatch("result arrived with no item outstanding");
                else
                begin
                    due = compare_due.pop_front();
                    if (m_axis_tdata !== {{(16 - CMP_W){1'b0}}, due.compare})
                        report_mismatch($sformatf("result %0d pwm_compare got %h want %h",
                            results_seen, m_axis_tdata, due.compare));
                    if (m_axis_tuser !== due.relay)
                        report_mismatch($sformatf("result %0d relay_on got %b want %b",
                            results_seen, m_axis_tuser, due.relay));
                end
            end
            if (cfg_valid && cfg_ready)
                scale_q = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                compare_due.push_back(control_tick(s_axis_tdata));
                samples_taken++;
            end
        end
    end

    initial
    begin : stimulus
        logic [SCALE_W-1:0] scale_pick;
        int                 run_len;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items at the reset scale, all in the feed-forward period:
        // code extremes, mid-range on either side, and alternating bit patterns.
        queue_sample('0, '0);
        queue_sample(CODE_MAX, CODE_MAX);
        queue_sample('0, CODE_MAX);
        queue_sample(CODE_MAX, '0);
        queue_sample(SMP_W'(ADC_MID), SMP_W'(ADC_MID));
        queue_sample(SMP_W'(ADC_MID - 1), SMP_W'(ADC_MID + 1));
        queue_sample(SMP_W'(ADC_MID + 1), SMP_W'(ADC_MID - 1));
        queue_sample(SMP_W'(ADC_MID - 512), SMP_W'(ADC_MID));
        queue_sample(SMP_W'(ADC_MID + 511), SMP_W'(ADC_MID));
        queue_sample(SMP_W'(ADC_MID + 512), SMP_W'(ADC_MID));
        queue_sample(12'hAAA, 12'h555);
        queue_sample(12'h555, 12'hAAA);
        queue_sample(12'h001, 12'hFFE);
        queue_sample(12'hFFE, 12'h001);
        queue_sample(12'h800, 12'h7FF);
        queue_sample(12'h7FF, 12'h800);
        wait_for_quiet();

        // Random phases, each at its own drive scale. The loop state carries
        // on across phases, so the scales land in all three periods.
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0:       scale_pick = '0;
                1:       scale_pick = SCALE_FULL;
                2:       scale_pick = SCALE_RESET;
                3:       scale_pick = SCALE_W'($urandom_range(4096, 262143));
                4:       scale_pick = SCALE_W'($urandom);
                default: scale_pick = SCALE_W'($urandom_range(16384, 98304));
            endcase
            write_scale(scale_pick);
            idling_on = (phase % 4 != 3);
            run_len = $urandom_range(80, 120);
            for (int n = 0; n < run_len; n++)
                queue_sample(draw_code(), draw_code());
            wait_for_quiet();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("pwm_current_loop_with_soft_start_core verification clean");
        else
            $display("pwm_current_loop_with_soft_start_core verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("pwm_current_loop_with_soft_start_core verification failed");
        $finish;
    end

endmodule
